/* rtl/core/filled_disk_pixel_scan_defines.svh */
// Assertion helpers shared by the block's modules.
`ifndef FILLED_DISK_PIXEL_SCAN_DEFINES_SVH
`define FILLED_DISK_PIXEL_SCAN_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FDPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FDPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fdps_pkg.sv */
`default_nettype none

package fdps_pkg;

    // Largest radius the scan handles; larger requests saturate to it.
    localparam logic [1:0] MAX_RADIUS = 2'd3;
    // Largest surface dimension; larger register values saturate to it.
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Configuration register indexes.
    localparam logic CFG_SURFACE_WIDTH  = 1'b0;
    localparam logic CFG_SURFACE_HEIGHT = 1'b1;

    // Input item: disk center and radius.
    typedef struct packed {
        logic signed [15:0] disk_x;
        logic signed [15:0] disk_y;
        logic [1:0]         disk_radius;
    } t_in_item;

    // Result item: one covered pixel.
    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        last_pixel;
    } t_out_item;

    // Load request from the sequencer to the output slot.
    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_out_load;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Square of a small signed offset in the range -3..3; -4 gives zero.
    function automatic logic [3:0] sq3(input logic signed [2:0] d);
        logic [3:0] res;
        begin
            unique case (d)
                3'sd0:  res = 4'd0;
                3'sd1:  res = 4'd1;
                -3'sd1: res = 4'd1;
                3'sd2:  res = 4'd4;
                -3'sd2: res = 4'd4;
                3'sd3:  res = 4'd9;
                -3'sd3: res = 4'd9;
                default: res = 4'd0;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fdps_cover.sv */
`default_nettype none

// Shared distance unit: tests one scan position against the disk.
module fdps_cover (
    input  wire logic [11:0]        i_x,
    input  wire logic [11:0]        i_y,
    input  wire logic signed [15:0] i_cx,
    input  wire logic signed [15:0] i_cy,
    input  wire logic [3:0]         i_r2,
    output logic                    o_covered
);
    import fdps_pkg::*;

    logic signed [17:0] dx_full;
    logic signed [17:0] dy_full;
    logic [4:0]         dist2;

    // Offsets stay within the radius inside the bounding box, so three bits hold them.
    always_comb begin
        dx_full = $signed({6'b0, i_x}) - 18'(i_cx);
        dy_full = $signed({6'b0, i_y}) - 18'(i_cy);
        dist2 = {1'b0, sq3(dx_full[2:0])} + {1'b0, sq3(dy_full[2:0])};
        o_covered = (dist2 <= {1'b0, i_r2});
    end

endmodule

`default_nettype wire

/* rtl/core/fdps_out_slot.sv */
`default_nettype none

// Output register: holds one result item until the receiver takes it.
module fdps_out_slot (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fdps_pkg::t_out_load i_load,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output fdps_pkg::t_out_item      o_item,
    output logic                     o_free
);
    import fdps_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // The slot can take a new item when empty or when its item leaves now.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_item <= i_load.item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/core/filled_disk_pixel_scan.sv */
// Filled disk pixel scan.
// An input item (disk_x, disk_y, disk_radius) arrives on the in channel;
// the block lists every surface pixel within radius of the center on the out
// channel, row by row from the top and left to right, with last_pixel set on
// the final one. A disk lying wholly off the surface gives no items.
// Surface width and height are written on the cfg channel (index 0 and 1);
// the user must write them only while the block is idle, which the block
// itself does not enforce; values above 4096 act as 4096.
// Steps: accept the item, set up the clipped bounding box, scan every
// bounding-box pixel through the shared distance unit, and release the
// held-back final pixel.
// The final covered pixel is held one position back so it can be flagged.
// When the receiver stalls, the scan waits whenever a covered pixel would
// overwrite a result not yet taken; no item is lost.
// in_ready is high only when the scan is idle; a finished result may still
// wait in the output register meanwhile. Reset empties the block and sets the
// surface to 4096 by 4096.
`default_nettype none

`include "filled_disk_pixel_scan_defines.svh"

module filled_disk_pixel_scan (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire fdps_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output fdps_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [12:0]         i_cfg_data
);
    import fdps_pkg::*;

    // Control state.
    t_state r_state, n_state;
    logic   r_pend_valid, n_pend_valid;
    logic [12:0] r_surf_w, r_surf_h;

    // Item and scan registers.
    logic signed [15:0] r_cx, r_cy;
    logic [1:0]  r_rad;
    logic [3:0]  r_r2, n_r2;
    logic [11:0] r_x, n_x, r_y, n_y;
    logic [11:0] r_x0, n_x0, r_x1, n_x1, r_y1, n_y1;
    logic [11:0] r_pend_x, n_pend_x, r_pend_y, n_pend_y;

    // Setup arithmetic.
    logic [12:0] w_clip, h_clip;
    logic signed [17:0] s_x0, s_x1, s_y0, s_y1, s_wm1, s_hm1;
    logic signed [17:0] c_x0, c_x1, c_y0, c_y1;
    logic [1:0]  rad_sat;

    logic      covered;
    logic      slot_free;
    logic      in_acc;
    t_out_load out_load;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w <= MAX_DIM;
            r_surf_h <= MAX_DIM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SURFACE_WIDTH:  r_surf_w <= i_cfg_data;
                CFG_SURFACE_HEIGHT: r_surf_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clipped bounding box of the latched disk.
    always_comb begin
        rad_sat = (r_rad > MAX_RADIUS) ? MAX_RADIUS : r_rad;
        w_clip  = (r_surf_w > MAX_DIM) ? MAX_DIM : r_surf_w;
        h_clip  = (r_surf_h > MAX_DIM) ? MAX_DIM : r_surf_h;
        s_wm1   = $signed({5'b0, w_clip}) - 18'sd1;
        s_hm1   = $signed({5'b0, h_clip}) - 18'sd1;
        s_x0    = 18'(r_cx) - $signed({16'b0, rad_sat});
        s_x1    = 18'(r_cx) + $signed({16'b0, rad_sat});
        s_y0    = 18'(r_cy) - $signed({16'b0, rad_sat});
        s_y1    = 18'(r_cy) + $signed({16'b0, rad_sat});
        c_x0    = (s_x0 < 18'sd0) ? 18'sd0 : s_x0;
        c_y0    = (s_y0 < 18'sd0) ? 18'sd0 : s_y0;
        c_x1    = (s_x1 > s_wm1) ? s_wm1 : s_x1;
        c_y1    = (s_y1 > s_hm1) ? s_hm1 : s_y1;
    end

    // Shared distance unit tests the current scan position.
    fdps_cover u_cover (
        .i_x       (r_x),
        .i_y       (r_y),
        .i_cx      (r_cx),
        .i_cy      (r_cy),
        .i_r2      (r_r2),
        .o_covered (covered)
    );

    fdps_out_slot u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_free  (slot_free)
    );

    // Sequencer: next state, scan counters and output loads.
    always_comb begin
        n_state      = r_state;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_r2         = r_r2;
        n_x          = r_x;
        n_y          = r_y;
        n_x0         = r_x0;
        n_x1         = r_x1;
        n_y1         = r_y1;
        out_load     = '0;
        out_load.item.pixel_x    = r_pend_x;
        out_load.item.pixel_y    = r_pend_y;
        out_load.item.last_pixel = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_r2         = sq3($signed({1'b0, rad_sat}));
                n_pend_valid = 1'b0;
                n_x0         = c_x0[11:0];
                n_x1         = c_x1[11:0];
                n_y1         = c_y1[11:0];
                n_x          = c_x0[11:0];
                n_y          = c_y0[11:0];
                if (c_x1 < c_x0 || c_y1 < c_y0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Stall when a covered pixel must push the held pixel out
                // and the output register is still occupied.
                if (!(covered && r_pend_valid && !slot_free)) begin
                    if (covered) begin
                        out_load.load = r_pend_valid;
                        n_pend_valid  = 1'b1;
                        n_pend_x      = r_x;
                        n_pend_y      = r_y;
                    end
                    if (r_x == r_x1) begin
                        n_x = r_x0;
                        if (r_y == r_y1) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_y = r_y + 12'd1;
                        end
                    end else begin
                        n_x = r_x + 12'd1;
                    end
                end
            end
            S_FLUSH: begin
                // Release the held pixel as the final one of the disk.
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    out_load.load            = 1'b1;
                    out_load.item.last_pixel = 1'b1;
                    n_pend_valid             = 1'b0;
                    n_state                  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Item and scan registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cx  <= i_in_item.disk_x;
            r_cy  <= i_in_item.disk_y;
            r_rad <= i_in_item.disk_radius;
        end
        r_r2     <= n_r2;
        r_x      <= n_x;
        r_y      <= n_y;
        r_x0     <= n_x0;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_pend_x <= n_pend_x;
        r_pend_y <= n_pend_y;
    end

    // The scan position stays inside the clipped box.
    `FDPS_ASSERT_IMP(a_scan_in_box, i_clk, i_rst_n, r_state == S_SCAN, r_x >= r_x0 && r_x <= r_x1 && r_y <= r_y1, "scan position outside the bounding box")
    // Only the flush step marks a result as the last one.
    `FDPS_ASSERT_IMP(a_last_from_flush, i_clk, i_rst_n, out_load.load && out_load.item.last_pixel, r_state == S_FLUSH, "last pixel emitted outside flush")
    // No pixel is held back while the block is idle.
    `FDPS_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_pend_valid, "held pixel left over in idle")
    // A load never overwrites a result that is still waiting.
    `FDPS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, out_load.load, slot_free, "output register overwritten")
    // An accepted item always goes through setup next.
    `FDPS_ASSERT_NXT(a_accept_setup, i_clk, i_rst_n, in_acc, r_state == S_SETUP, "accepted item skipped setup")

endmodule

`default_nettype wire
